/* rtl/core/multitap_keypad_text_entry_top_defines.svh */
// ---------------------------------------------------------------------------
// Multitap keypad text entry - assertion macros
// Concurrent assertion wrappers. They compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_TOP_DEFINES_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define MKTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MKTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MKTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MKTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/mkte_pkg.sv */
// ---------------------------------------------------------------------------
// Multitap keypad text entry - package
// Field widths, action codes, chord patterns and the letter table.
// ---------------------------------------------------------------------------
package mkte_pkg;

    localparam int KEY_W  = 9;
    localparam int ACT_W  = 2;
    localparam int CHAR_W = 7;
    localparam int KIDX_W = 4;
    localparam int TAP_W  = 2;

    typedef logic [KEY_W-1:0]  key_bits_t;
    typedef logic [ACT_W-1:0]  action_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [KIDX_W-1:0] key_idx_t;
    typedef logic [TAP_W-1:0]  tap_t;

    localparam action_t ACT_NONE    = 2'd0;
    localparam action_t ACT_APPEND  = 2'd1;
    localparam action_t ACT_REPLACE = 2'd2;
    localparam action_t ACT_CLEAR   = 2'd3;

    localparam key_idx_t NO_KEY    = 4'd15;
    localparam key_idx_t NUM_KEYS  = 4'd9;

    localparam key_bits_t CHORD_CLEAR = 9'h006;
    localparam key_bits_t CHORD_MODE  = 9'h030;
    localparam key_bits_t CHORD_SPACE = 9'h180;

    localparam char_t CHAR_ONE   = 7'h31;
    localparam char_t CHAR_SPACE = 7'h20;
    localparam char_t CHAR_NUL   = 7'h00;

    localparam char_t LETTERS [9][3] = '{
        '{7'h2E, 7'h51, 7'h5A},   // . Q Z
        '{7'h41, 7'h42, 7'h43},   // A B C
        '{7'h44, 7'h45, 7'h46},   // D E F
        '{7'h47, 7'h48, 7'h49},   // G H I
        '{7'h4A, 7'h4B, 7'h4C},   // J K L
        '{7'h4D, 7'h4E, 7'h4F},   // M N O
        '{7'h50, 7'h52, 7'h53},   // P R S
        '{7'h54, 7'h55, 7'h56},   // T U V
        '{7'h57, 7'h58, 7'h59}    // W X Y
    };

    // Letter lookup; out-of-range codes give NUL.
    function automatic char_t letter_of(key_idx_t key, tap_t tap);
        char_t ch;
        ch = CHAR_NUL;
        if ((key < NUM_KEYS) && (tap != 2'd3))
        begin
            ch = LETTERS[key][tap];
        end
        return ch;
    endfunction

    // Tap advance modulo three; the unused code 3 folds to 1.
    function automatic tap_t tap_advance(tap_t tap);
        tap_t nxt;
        case (tap)
            2'd0:    nxt = 2'd1;
            2'd1:    nxt = 2'd2;
            2'd2:    nxt = 2'd0;
            default: nxt = 2'd1;
        endcase
        return nxt;
    endfunction

endpackage

/* rtl/core/mkte_if.sv */
// ---------------------------------------------------------------------------
// Multitap keypad text entry - channel interfaces
// Valid/ready channels for key presses and text edits.
// ---------------------------------------------------------------------------
interface mkte_key_if;
    logic               valid;
    logic               ready;
    mkte_pkg::key_bits_t key_bits;

    modport source (output valid, output key_bits, input ready);
    modport sink   (input valid, input key_bits, output ready);
endinterface

interface mkte_edit_if;
    logic              valid;
    logic              ready;
    mkte_pkg::action_t edit_action;
    mkte_pkg::char_t   char_code;
    logic              digit_mode;

    modport source (output valid, output edit_action, output char_code,
                    output digit_mode, input ready);
    modport sink   (input valid, input edit_action, input char_code,
                    input digit_mode, output ready);
endinterface

/* rtl/core/multitap_keypad_text_entry_top.sv */
// An accepted key press shows its edit at the output in the next cycle.
// Throughput: one press per cycle unless a waiting result is held by edit_out.ready low;
// the single result register drains and refills at once. key_in.ready drops only while a
// result waits and edit_out.ready is low. Reset (rst_n low, async): no key remembered,
// tap 0, letter mode, output empty.
// Multitap keypad text entry - top level
// Decodes nine-key pad presses into append / replace / clear / none text edits.
// ---------------------------------------------------------------------------
`include "multitap_keypad_text_entry_top_defines.svh"

module multitap_keypad_text_entry_top (
    input  logic        clk,
    input  logic        rst_n,
    mkte_key_if.sink    key_in,
    mkte_edit_if.source edit_out
);

    // -----------------------------------------------------------------------
    // Edit state: last letter-mode key, its tap position, and the mode flag.
    // -----------------------------------------------------------------------
    mkte_pkg::key_idx_t last_key_reg, last_key_next;
    mkte_pkg::tap_t     tap_reg, tap_next;
    logic               numeric_reg, numeric_next;

    // Result register
    logic               out_valid_reg;
    mkte_pkg::action_t  act_reg, act_next;
    mkte_pkg::char_t    char_reg, char_next;
    logic               mode_reg;

    logic               in_fire;
    logic               single;
    mkte_pkg::key_idx_t key_idx;

    // Accept whenever the result slot is empty or being drained this cycle.
    assign key_in.ready = !out_valid_reg || edit_out.ready;
    assign in_fire      = key_in.valid && key_in.ready;

    // One-hot to index: nine independent compares.
    always_comb
    begin
        single  = $onehot(key_in.key_bits);
        key_idx = mkte_pkg::NUM_KEYS;
        for (int i = 0; i < mkte_pkg::KEY_W; i++)
        begin
            if (key_in.key_bits == mkte_pkg::key_bits_t'(1 << i))
            begin
                key_idx = mkte_pkg::key_idx_t'(i);
            end
        end
    end

    // Next state and result for the presented press.
    always_comb
    begin
        last_key_next = last_key_reg;
        tap_next      = tap_reg;
        numeric_next  = numeric_reg;
        act_next      = mkte_pkg::ACT_NONE;
        char_next     = mkte_pkg::CHAR_NUL;

        if (single)
        begin
            if (numeric_reg)
            begin
                // digit mode: '1'..'9', tap state untouched
                act_next  = mkte_pkg::ACT_APPEND;
                char_next = mkte_pkg::CHAR_ONE
                            + mkte_pkg::char_t'(key_idx);
            end
            else if (last_key_reg == key_idx)
            begin
                // same key again: step to the next letter in place
                tap_next  = mkte_pkg::tap_advance(tap_reg);
                act_next  = mkte_pkg::ACT_REPLACE;
                char_next = mkte_pkg::letter_of(key_idx, tap_next);
            end
            else
            begin
                // new key: first letter appended
                tap_next      = 2'd0;
                last_key_next = key_idx;
                act_next      = mkte_pkg::ACT_APPEND;
                char_next     = mkte_pkg::letter_of(key_idx, 2'd0);
            end
        end
        else if (key_in.key_bits == mkte_pkg::CHORD_CLEAR)
        begin
            last_key_next = mkte_pkg::NO_KEY;
            act_next      = mkte_pkg::ACT_CLEAR;
        end
        else if (key_in.key_bits == mkte_pkg::CHORD_MODE)
        begin
            numeric_next = !numeric_reg;
        end
        else if (key_in.key_bits == mkte_pkg::CHORD_SPACE)
        begin
            act_next  = mkte_pkg::ACT_APPEND;
            char_next = mkte_pkg::CHAR_SPACE;
        end
    end

    // Control state, updated on every accepted transaction; the valid flag also clears on drain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg  <= mkte_pkg::NO_KEY;
            tap_reg       <= 2'd0;
            numeric_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                last_key_reg  <= last_key_next;
                tap_reg       <= tap_next;
                numeric_reg   <= numeric_next;
                out_valid_reg <= 1'b1;
            end
            else if (edit_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the result register, loaded only on accept.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg  <= act_next;
            char_reg <= char_next;
            mode_reg <= numeric_next;
        end
    end

    assign edit_out.valid       = out_valid_reg;
    assign edit_out.edit_action = act_reg;
    assign edit_out.char_code   = char_reg;
    assign edit_out.digit_mode  = mode_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    // tap position never reaches the unused code
    `MKTE_ASSERT_IMP(a_tap_range, clk, rst_n, 1'b1, tap_reg != 2'd3)
    // clear chord forgets the last key
    `MKTE_ASSERT_NXT(a_clear_forgets, clk, rst_n,
        in_fire && (key_in.key_bits == mkte_pkg::CHORD_CLEAR),
        last_key_reg == mkte_pkg::NO_KEY)
    // replace edits only come from letter mode
    `MKTE_ASSERT_IMP(a_replace_letters, clk, rst_n,
        out_valid_reg && (act_reg == mkte_pkg::ACT_REPLACE), !mode_reg)
    // no character rides with a none or clear edit
    `MKTE_ASSERT_IMP(a_nul_char, clk, rst_n,
        out_valid_reg && ((act_reg == mkte_pkg::ACT_NONE) ||
                          (act_reg == mkte_pkg::ACT_CLEAR)),
        char_reg == mkte_pkg::CHAR_NUL)

endmodule
